// ===== hdl/msw_pkg.sv =====
// shared constants for the three-window maximum sum block
// status codes and field widths, used by the top level and its checker
package msw_pkg;

    localparam int MAX_LENGTH_DEF  = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int WIN_LEN_W = 9;
    localparam int START_W   = 10;
    localparam int STATUS_W  = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SHORT    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

endpackage

// ===== hdl/max_sum_three_windows.sv =====
// Maximum sum of three non-overlapping windows, constants from msw_pkg.
//
// Input channel: one sample beat per element (i_sample_value, i_is_last), taken
// when i_in_valid is high and o_in_stall is low. The last beat closes the sequence.
// Output channel: one result beat per sequence (three start indices and o_status),
// held on the o_ ports while o_out_valid is high and i_out_stall is high.
// Config: i_cfg_wr_en with i_cfg_wr_data writes the window length k; a length of
// zero counts as one. The length is sampled at the first beat of a sequence.
// Loading: each stored sample is accepted, then the input stalls for the running-sum
// update, which waits on the registered read of the sample k places back; beats past
// the store are dropped at one per cycle. With n samples and P = n - 3k + 1 window
// positions, the last beat is followed by the running-sum update, the status check,
// the setup, the backward pass over the P - 1 earlier starts and the forward pass over
// all P starts (both bound by the single read port of the window-sum store feeding
// one shared add-and-compare unit), then the load. A short sequence skips both passes,
// an overflowed one too, and it also skips the running-sum update of its last beat.
// While the output register is full and stalled the next sequence still loads;
// only the hand-over of a new result waits for the receiver.
// Reset (synchronous, active low) empties the sequence, sets k to 1 and drops any
// pending result. The stores are not cleared: every entry read was written first.
module max_sum_three_windows
    import msw_pkg::*;
#(
    parameter int MAX_LENGTH  = MAX_LENGTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [WIN_LEN_W-1:0]   i_cfg_wr_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [SAMPLE_BITS-1:0] i_sample_value,
    input  logic                   i_is_last,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [START_W-1:0]     o_first_start,
    output logic [START_W-1:0]     o_second_start,
    output logic [START_W-1:0]     o_third_start,
    output logic [STATUS_W-1:0]    o_status
);

    localparam int IDX_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int CNT_W = $clog2(MAX_LENGTH + 1);
    localparam int SUM_W = SAMPLE_BITS + WIN_LEN_W + 1;
    localparam int TOT_W = SUM_W + 2;
    localparam int CW    = ((CNT_W > WIN_LEN_W + 2) ? CNT_W : WIN_LEN_W + 2) + 1;

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_LSUM = 14'b00000000000010,
        S_CHK  = 14'b00000000000100,
        S_I1   = 14'b00000000001000,
        S_I2   = 14'b00000000010000,
        S_I3   = 14'b00000000100000,
        S_B3   = 14'b00000001000000,
        S_B2   = 14'b00000010000000,
        S_BC   = 14'b00000100000000,
        S_FRB  = 14'b00001000000000,
        S_FW1  = 14'b00010000000000,
        S_FW2  = 14'b00100000000000,
        S_FW3  = 14'b01000000000000,
        S_DONE = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    // stores
    logic [SAMPLE_BITS-1:0] r_smp_mem [MAX_LENGTH];
    logic [SUM_W-1:0]       r_ws_mem  [MAX_LENGTH];
    logic [IDX_W-1:0]       r_b2_mem  [MAX_LENGTH];
    logic [IDX_W-1:0]       r_b3_mem  [MAX_LENGTH];
    logic [SAMPLE_BITS-1:0] r_smp_rd;
    logic [SUM_W-1:0]       r_ws_rd;
    logic [IDX_W-1:0]       r_b2_rd;
    logic [IDX_W-1:0]       r_b3_rd;

    // sequence state
    logic [WIN_LEN_W-1:0]   r_win_len;
    logic [WIN_LEN_W-1:0]   r_k;
    logic [CNT_W-1:0]       r_count;
    logic [SUM_W-1:0]       r_rsum;
    logic                   r_ovf;
    logic [SAMPLE_BITS-1:0] r_samp;
    logic                   r_last;

    // search state
    logic [IDX_W-1:0]    r_lp;
    logic [IDX_W-1:0]    r_nk;
    logic [IDX_W-1:0]    r_n2k;
    logic [IDX_W-1:0]    r_i;
    logic [SUM_W-1:0]    r_third_val;
    logic [IDX_W-1:0]    r_third_idx;
    logic [TOT_W-1:0]    r_best_pair;
    logic [IDX_W-1:0]    r_b2;
    logic [IDX_W-1:0]    r_b3;
    logic [TOT_W-1:0]    r_acc;
    logic [TOT_W-1:0]    r_best;
    logic                r_first;
    logic [IDX_W-1:0]    r_a;
    logic [IDX_W-1:0]    r_b;
    logic [IDX_W-1:0]    r_c;
    logic [STATUS_W-1:0] r_status;

    // output register
    logic                r_out_valid;
    logic [START_W-1:0]  r_out_a;
    logic [START_W-1:0]  r_out_b;
    logic [START_W-1:0]  r_out_c;
    logic [STATUS_W-1:0] r_out_status;

    logic                 in_acc;
    logic                 store_ok;
    logic [WIN_LEN_W-1:0] k_now;
    logic [IDX_W-1:0]     smp_rd_addr;
    logic                 sub_old;
    logic                 ws_wr;
    logic [IDX_W-1:0]     ws_wr_addr;
    logic [SUM_W-1:0]     rsum_next;
    logic [IDX_W-1:0]     ws_addr;
    logic [IDX_W-1:0]     idx_k;
    logic [IDX_W-1:0]     idx_2k;
    logic [CW-1:0]        k1;
    logic [CW-1:0]        k3;
    logic                 bc_wr;
    logic [IDX_W-1:0]     bc_b2;
    logic [IDX_W-1:0]     bc_b3;
    logic                 out_load;

    // shared add-and-compare unit
    logic [TOT_W-1:0] u_a, u_b, u_c, u_sum;
    logic             u_ge, u_eq;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign store_ok = !r_ovf && (r_count < CNT_W'(MAX_LENGTH));
    assign k_now    = (r_count == '0 && !r_ovf)
                      ? ((r_win_len == '0) ? WIN_LEN_W'(1) : r_win_len) : r_k;
    assign smp_rd_addr = IDX_W'(CW'(r_count) - CW'(k_now));

    assign k1 = CW'(r_k);
    assign k3 = k1 + (k1 << 1);
    assign idx_k  = IDX_W'(CW'(r_i) + k1);
    assign idx_2k = IDX_W'(CW'(r_i) + (k1 << 1));

    assign sub_old    = CW'(r_count) >= k1;
    assign ws_wr      = (r_state == S_LSUM) && (CW'(r_count) + CW'(1) >= k1);
    assign ws_wr_addr = IDX_W'(CW'(r_count) + CW'(1) - k1);
    assign rsum_next  = r_rsum + SUM_W'(r_samp) - (sub_old ? SUM_W'(r_smp_rd) : '0);

    assign u_sum = u_a + u_b;
    assign u_ge  = u_sum >= u_c;
    assign u_eq  = u_sum == u_c;

    always_comb begin
        u_a = TOT_W'(r_ws_rd);
        u_b = '0;
        u_c = '0;
        unique case (r_state)
            S_I3: begin
                u_b = TOT_W'(r_third_val);
            end
            S_B2: begin
                u_c = TOT_W'(r_third_val);
            end
            S_BC: begin
                u_b = TOT_W'(r_third_val);
                u_c = r_best_pair;
            end
            S_FW2: begin
                u_b = r_acc;
            end
            S_FW3: begin
                u_b = r_acc;
                u_c = r_best;
            end
            default: begin
                u_a = TOT_W'(r_ws_rd);
            end
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_I1:    ws_addr = r_nk;
            S_I2:    ws_addr = r_n2k;
            S_B3:    ws_addr = idx_2k;
            S_B2:    ws_addr = idx_k;
            S_FW1:   ws_addr = r_b2_rd;
            S_FW2:   ws_addr = r_b3_rd;
            default: ws_addr = r_i;
        endcase
    end

    // backward pass keeps the running best pair and writes it for every start
    assign bc_wr = (r_state == S_BC) && u_ge;
    assign bc_b2 = bc_wr ? idx_k : r_b2;
    assign bc_b3 = bc_wr ? r_third_idx : r_b3;

    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (store_ok)
                        n_state = S_LSUM;
                    else if (i_is_last)
                        n_state = S_CHK;
                end
            end
            S_LSUM: n_state = r_last ? S_CHK : S_IDLE;
            S_CHK: begin
                if (!r_ovf && CW'(r_count) >= k3)
                    n_state = S_I1;
                else
                    n_state = S_DONE;
            end
            S_I1:  n_state = S_I2;
            S_I2:  n_state = S_I3;
            S_I3:  n_state = (r_lp == '0) ? S_FRB : S_B3;
            S_B3:  n_state = S_B2;
            S_B2:  n_state = S_BC;
            S_BC:  n_state = (r_i == '0) ? S_FRB : S_B3;
            S_FRB: n_state = S_FW1;
            S_FW1: n_state = S_FW2;
            S_FW2: n_state = S_FW3;
            S_FW3: n_state = (r_i == r_lp) ? S_DONE : S_FRB;
            S_DONE: begin
                if (out_load)
                    n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // stores, registered read ports
    always_ff @(posedge i_clk) begin
        if (in_acc && store_ok)
            r_smp_mem[r_count[IDX_W-1:0]] <= i_sample_value;
        r_smp_rd <= r_smp_mem[smp_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (ws_wr)
            r_ws_mem[ws_wr_addr] <= rsum_next;
        r_ws_rd <= r_ws_mem[ws_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_I3) begin
            r_b2_mem[r_lp] <= r_n2k;
            r_b3_mem[r_lp] <= r_nk;
        end else if (r_state == S_BC) begin
            r_b2_mem[r_i] <= bc_b2;
            r_b3_mem[r_i] <= bc_b3;
        end
        r_b2_rd <= r_b2_mem[r_i];
        r_b3_rd <= r_b3_mem[r_i];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_win_len   <= WIN_LEN_W'(1);
            r_k         <= WIN_LEN_W'(1);
            r_count     <= '0;
            r_rsum      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en)
                r_win_len <= i_cfg_wr_data;
            if (in_acc) begin
                r_k <= k_now;
                if (!store_ok)
                    r_ovf <= 1'b1;
            end
            if (r_state == S_LSUM) begin
                r_rsum  <= rsum_next;
                r_count <= r_count + CNT_W'(1);
            end
            if (r_state == S_CHK) begin
                r_count <= '0;
                r_rsum  <= '0;
                r_ovf   <= 1'b0;
            end
            if (out_load)
                r_out_valid <= 1'b1;
            else if (!i_out_stall)
                r_out_valid <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_samp <= i_sample_value;
            r_last <= i_is_last;
        end
        unique case (r_state)
            S_CHK: begin
                r_a   <= '0;
                r_b   <= '0;
                r_c   <= '0;
                r_lp  <= IDX_W'(CW'(r_count) - k3);
                r_nk  <= IDX_W'(CW'(r_count) - k1);
                r_n2k <= IDX_W'(CW'(r_count) - (k1 << 1));
                if (r_ovf)
                    r_status <= STATUS_OVERFLOW;
                else if (CW'(r_count) < k3)
                    r_status <= STATUS_SHORT;
                else
                    r_status <= STATUS_OK;
            end
            S_I2: begin
                r_third_val <= r_ws_rd;
                r_third_idx <= r_nk;
            end
            S_I3: begin
                r_best_pair <= u_sum;
                r_b2        <= r_n2k;
                r_b3        <= r_nk;
                r_first     <= 1'b1;
                r_i         <= (r_lp == '0) ? '0 : r_lp - IDX_W'(1);
            end
            S_B2: begin
                // earlier window wins ties on the third start
                if (u_ge) begin
                    r_third_val <= r_ws_rd;
                    r_third_idx <= idx_2k;
                end
            end
            S_BC: begin
                if (bc_wr)
                    r_best_pair <= u_sum;
                r_b2 <= bc_b2;
                r_b3 <= bc_b3;
                if (r_i != '0)
                    r_i <= r_i - IDX_W'(1);
            end
            S_FW1: r_acc <= TOT_W'(r_ws_rd);
            S_FW2: r_acc <= u_sum;
            S_FW3: begin
                // strictly greater keeps the smallest first start
                if (r_first || (u_ge && !u_eq)) begin
                    r_best <= u_sum;
                    r_a    <= r_i;
                    r_b    <= r_b2_rd;
                    r_c    <= r_b3_rd;
                end
                r_first <= 1'b0;
                if (r_i != r_lp)
                    r_i <= r_i + IDX_W'(1);
            end
            default: begin
                r_first <= r_first;
            end
        endcase
        if (out_load) begin
            r_out_a      <= START_W'(r_a);
            r_out_b      <= START_W'(r_b);
            r_out_c      <= START_W'(r_c);
            r_out_status <= r_status;
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_first_start  = r_out_a;
    assign o_second_start = r_out_b;
    assign o_third_start  = r_out_c;
    assign o_status       = r_out_status;

endmodule

// ===== hdl/msw_checker.sv =====
// port-level checks for the three-window maximum sum block
// depends on msw_pkg; bound to max_sum_three_windows at the end of this file
module msw_checker
    import msw_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                i_is_last,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [START_W-1:0]  o_first_start,
    input logic [START_W-1:0]  o_second_start,
    input logic [START_W-1:0]  o_third_start,
    input logic [STATUS_W-1:0] o_status
);

    // a last beat always ends the loading, so the input side stalls next cycle
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_is_last) |=> o_in_stall)
        else $error("input not stalled after last beat");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == STATUS_OK || o_status == STATUS_SHORT
                         || o_status == STATUS_OVERFLOW))
        else $error("undefined status code");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != STATUS_OK) |->
        (o_first_start == '0 && o_second_start == '0 && o_third_start == '0))
        else $error("failed result carries start indices");

    a_ok_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STATUS_OK) |->
        (o_first_start < o_second_start && o_second_start < o_third_start))
        else $error("window starts out of order");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_first_start) && $stable(o_second_start)
         && $stable(o_third_start) && $stable(o_status)))
        else $error("stalled result beat changed");

endmodule

bind max_sum_three_windows msw_checker u_msw_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_is_last      (i_is_last),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_first_start  (o_first_start),
    .o_second_start (o_second_start),
    .o_third_start  (o_third_start),
    .o_status       (o_status)
);

// ===== dv/max_sum_three_windows_test.sv =====
`timescale 1ns / 1ps
// self-checking bench for max_sum_three_windows: directed and random sample sequences
// under random input gaps and output stalls, each result checked against a recomputed triple
// depends on msw_pkg and the max_sum_three_windows rtl

module max_sum_three_windows_test;
    import msw_pkg::*;

    localparam int STORE_DEPTH     = MAX_LENGTH_DEF;
    localparam int SAMPLE_W        = SAMPLE_BITS_DEF;
    localparam int RANDOM_ITEMS    = 840;
    localparam int MIN_RANDOM_SEQS = 12;
    localparam int SETTLE_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        logic [START_W-1:0]  first_start;
        logic [START_W-1:0]  second_start;
        logic [START_W-1:0]  third_start;
        logic [STATUS_W-1:0] status;
    } t_triple;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    typedef enum logic [1:0] {
        FILL_RANDOM,
        FILL_TIES,
        FILL_EXTREMES,
        FILL_RAMP
    } t_fill_style;

    class t_best_triple_tracker;
        logic [SAMPLE_W-1:0] sample_mem [STORE_DEPTH];
        longint unsigned     window_sums [STORE_DEPTH];
        int unsigned         later_second [STORE_DEPTH];
        int unsigned         later_third [STORE_DEPTH];
        int unsigned         fill_count;
        longint unsigned     running;
        bit                  dropped;
        int unsigned         seq_window;
        int unsigned         cfg_window;
        t_triple             pending_triples [$];
        int                  mismatches;

        function new();
            fill_count = 0;
            running    = 0;
            dropped    = 1'b0;
            seq_window = 1;
            cfg_window = 1;
            mismatches = 0;
        endfunction

        function void set_window(input int unsigned len);
            cfg_window = len % 512;
        endfunction

        function int pending();
            return pending_triples.size();
        endfunction

        // backward pass keeps the best later pair per first start, forward pass picks the first
        function void pick_triple(input int unsigned n, input int unsigned k,
                                  output int unsigned a, output int unsigned b,
                                  output int unsigned c);
            int unsigned     positions, third, third_cand, second_cand, m, i;
            longint unsigned best_pair, best, cur;
            positions   = n - 3 * k + 1;
            third       = n - k;
            third_cand  = n - k - 1;
            second_cand = n - 2 * k - 1;
            best_pair   = window_sums[n - k] + window_sums[n - 2 * k];
            later_second[positions - 1] = n - 2 * k;
            later_third[positions - 1]  = n - k;
            for (m = positions - 1; m > 0; m--) begin
                i = m - 1;
                if (window_sums[third] <= window_sums[third_cand])
                    third = third_cand;
                cur = window_sums[second_cand] + window_sums[third];
                if (cur >= best_pair) begin
                    best_pair       = cur;
                    later_second[i] = second_cand;
                    later_third[i]  = third;
                end else begin
                    later_second[i] = later_second[i + 1];
                    later_third[i]  = later_third[i + 1];
                end
                second_cand--;
                third_cand--;
            end
            a = 0;
            b = later_second[0];
            c = later_third[0];
            best = window_sums[0] + window_sums[b] + window_sums[c];
            for (i = 1; i < positions; i++) begin
                cur = window_sums[i] + window_sums[later_second[i]]
                      + window_sums[later_third[i]];
                if (cur > best) begin
                    best = cur;
                    a    = i;
                    b    = later_second[i];
                    c    = later_third[i];
                end
            end
        endfunction

        function void note_sample(input logic [SAMPLE_W-1:0] value, input logic last);
            t_triple             want;
            int unsigned         k, idx, a, b, c;
            logic [STATUS_W-1:0] st;
            // window length is latched on the first beat of a sequence
            if (fill_count == 0 && !dropped)
                seq_window = (cfg_window == 0) ? 1 : cfg_window;
            k = seq_window;
            if (!dropped && fill_count < STORE_DEPTH) begin
                idx = fill_count;
                sample_mem[idx] = value;
                running += value;
                if (idx >= k)
                    running -= sample_mem[idx - k];
                if (idx + 1 >= k)
                    window_sums[idx + 1 - k] = running;
                fill_count++;
            end else begin
                dropped = 1'b1;
            end
            if (!last)
                return;
            a = 0;
            b = 0;
            c = 0;
            if (dropped) begin
                st = STATUS_OVERFLOW;
            end else if (fill_count < 3 * k) begin
                st = STATUS_SHORT;
            end else begin
                st = STATUS_OK;
                pick_triple(fill_count, k, a, b, c);
            end
            want.first_start  = a[START_W-1:0];
            want.second_start = b[START_W-1:0];
            want.third_start  = c[START_W-1:0];
            want.status       = st;
            pending_triples.push_back(want);
            fill_count = 0;
            running    = 0;
            dropped    = 1'b0;
        endfunction

        function void check_triple(input t_triple got);
            t_triple want;
            if (pending_triples.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result beat: %0d %0d %0d status %0d",
                             got.first_start, got.second_start, got.third_start, got.status);
                return;
            end
            want = pending_triples.pop_front();
            if (got.first_start !== want.first_start || got.second_start !== want.second_start
                    || got.third_start !== want.third_start || got.status !== want.status) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch: exp %0d %0d %0d st %0d, got %0d %0d %0d st %0d",
                             want.first_start, want.second_start, want.third_start,
                             want.status, got.first_start, got.second_start,
                             got.third_start, got.status);
            end
        endfunction
    endclass

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_cfg_wr_en    = 1'b0;
    logic [WIN_LEN_W-1:0]   i_cfg_wr_data  = '0;
    logic                   i_in_valid     = 1'b0;
    logic                   o_in_stall;
    logic [SAMPLE_W-1:0]    i_sample_value = '0;
    logic                   i_is_last      = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_stall    = 1'b0;
    logic [START_W-1:0]     o_first_start;
    logic [START_W-1:0]     o_second_start;
    logic [START_W-1:0]     o_third_start;
    logic [STATUS_W-1:0]    o_status;

    t_best_triple_tracker tracker;
    int                   burst_left  = 0;
    int                   idle_cycles = 0;
    t_stall_mode          stall_mode  = STALL_NONE;
    int                   stall_run   = 0;
    logic [31:0]          stall_phase = '0;

    max_sum_three_windows uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample_value (i_sample_value),
        .i_is_last      (i_is_last),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_first_start  (o_first_start),
        .o_second_start (o_second_start),
        .o_third_start  (o_third_start),
        .o_status       (o_status)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // receiver stall pattern, switching to a random style at the end of each random-length run
    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_run  = $urandom_range(8, 80);
        end
        stall_run   = stall_run - 1;
        stall_phase = stall_phase + 1;
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            default:     i_out_stall <= stall_phase[2];
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.check_triple({o_first_start, o_second_start, o_third_start, o_status});
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("max_sum_three_windows test failed");
            $finish;
        end
    end

    task automatic send_beat(input logic [SAMPLE_W-1:0] value, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid     <= 1'b0;
                i_sample_value <= SAMPLE_W'($urandom);
                i_is_last      <= 1'($urandom);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_sample_value <= value;
        i_is_last      <= last;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_sample(value, last);
        burst_left--;
    endtask

    task automatic send_values(input int unsigned vals [$]);
        for (int i = 0; i < vals.size(); i++)
            send_beat(vals[i][SAMPLE_W-1:0], i == vals.size() - 1);
    endtask

    task automatic send_sequence(input int len, input t_fill_style style);
        logic [SAMPLE_W-1:0] v;
        for (int i = 0; i < len; i++) begin
            case (style)
                FILL_RANDOM:   v = SAMPLE_W'($urandom);
                FILL_TIES:     v = SAMPLE_W'($urandom_range(0, 2));
                FILL_EXTREMES: v = $urandom_range(0, 1) ? '1 : '0;
                default:       v = SAMPLE_W'(i * 997);
            endcase
            send_beat(v, i == len - 1);
        end
    endtask

    // drop valid, let every result drain and the block settle before touching the length
    task automatic quiesce();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(input int unsigned len);
        quiesce();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= len[WIN_LEN_W-1:0];
        tracker.set_window(len);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int          rand_items;
        int          rand_seqs;
        int unsigned k;
        int unsigned eff;
        int          len;

        tracker = new();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_window(1);
        send_values('{65535, 0, 65535});
        send_values('{0, 65535});
        send_values('{7});
        send_values('{5, 5, 5, 5, 5});
        send_values('{0, 0, 0, 0});
        send_values('{1, 2, 65535, 3, 65535, 65535, 4});

        // zero length behaves as one
        write_window(0);
        send_values('{3, 1, 4, 1, 5});
        send_values('{9, 9});

        write_window(2);
        send_values('{43690, 21845, 43690, 21845, 65535, 1});
        send_values('{1, 2, 3, 4, 5});

        write_window(341);
        send_sequence(12, FILL_EXTREMES);

        rand_items = 0;
        rand_seqs  = 0;
        while (rand_items < RANDOM_ITEMS || rand_seqs < MIN_RANDOM_SEQS) begin
            case ($urandom_range(0, 9))
                0:       k = 0;
                1, 2:    k = 1;
                3:       k = 2;
                4:       k = 3;
                8:       k = $urandom_range(9, 20);
                9:       k = $urandom_range(21, 60);
                default: k = $urandom_range(1, 8);
            endcase
            write_window(k);
            eff = (k == 0) ? 1 : k;
            repeat ($urandom_range(3, 8)) begin
                if (rand_items < RANDOM_ITEMS || rand_seqs < MIN_RANDOM_SEQS) begin
                    if ($urandom_range(0, 9) == 0)
                        len = $urandom_range(1, 3 * eff - 1);
                    else
                        len = 3 * eff + $urandom_range(0, 24);
                    send_sequence(len, t_fill_style'($urandom_range(0, 3)));
                    rand_items += len;
                    rand_seqs++;
                end
            end
        end

        quiesce();
        if (tracker.pending() != 0)
            $display("%0d expected results never arrived", tracker.pending());
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("max_sum_three_windows test passed");
        else
            $display("max_sum_three_windows test failed");
        $finish;
    end

endmodule
